// ===== rtl/cyclic_negacyclic_poly_multiplier_top_defines.svh =====
// Assertion macros for the polynomial multiplier.
`ifndef CYCLIC_NEGACYCLIC_POLY_MULTIPLIER_TOP_DEFINES_SVH
`define CYCLIC_NEGACYCLIC_POLY_MULTIPLIER_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CNPM_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define CNPM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/cnpm_pkg.sv =====
// Shared types and constants for the polynomial multiplier.
package cnpm_pkg;

   localparam int unsigned DEFAULT_MAX_LENGTH = 512;
   localparam int unsigned COEFF_WIDTH        = 9;
   localparam int unsigned INDEX_WIDTH        = 9;
   localparam int unsigned CMD_WIDTH          = 2;
   localparam int unsigned LENGTH_WIDTH       = 10;
   localparam int unsigned CSR_INDEX_WIDTH    = 4;
   localparam int unsigned CSR_DATA_WIDTH     = 10;
   localparam int unsigned RESET_RING_LENGTH  = 512;
   localparam int unsigned MIN_RING_LENGTH    = 2;

   localparam int unsigned COEFF_MOD   = 499;
   localparam int unsigned PROD_WIDTH  = 2 * COEFF_WIDTH;
   localparam int unsigned MOD_SHIFT   = 27;
   localparam int unsigned MOD_RECIP   = (1 << MOD_SHIFT) / COEFF_MOD;
   localparam int unsigned RECIP_WIDTH = 19;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REDUCTION_MODE = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RING_LENGTH    = 4'd1;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_LOAD_FIRST  = 2'd0,
      CMD_LOAD_SECOND = 2'd1,
      CMD_MULTIPLY    = 2'd2,
      CMD_READ        = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRAP_Q,
      ST_WRAP_R,
      ST_EXEC,
      ST_READ,
      ST_MUL_RUN,
      ST_MUL_DRAIN,
      ST_MUL_CLEAR
   } state_type;

   typedef struct packed {
      logic valid;
      logic neg;
      logic first;
      logic last;
   } mac_ctl_type;

endpackage

// ===== rtl/cnpm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module cnpm_ram #(
   parameter int unsigned WIDTH = cnpm_pkg::COEFF_WIDTH,
   parameter int unsigned DEPTH = cnpm_pkg::DEFAULT_MAX_LENGTH
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/cnpm_mac.sv =====
// Pipelined multiply, reduce mod 499, optional negate and modular accumulate.
module cnpm_mac (
   input  logic                                clock,
   input  logic                                reset,
   input  cnpm_pkg::mac_ctl_type               ctl,
   input  logic [cnpm_pkg::COEFF_WIDTH-1:0]    op_a,
   input  logic [cnpm_pkg::COEFF_WIDTH-1:0]    op_b,
   output logic                                res_valid,
   output logic [cnpm_pkg::COEFF_WIDTH-1:0]    res_coeff
);

   localparam int unsigned CW = cnpm_pkg::COEFF_WIDTH;
   localparam int unsigned PW = cnpm_pkg::PROD_WIDTH;
   localparam int unsigned WW = PW + cnpm_pkg::RECIP_WIDTH;
   localparam int unsigned RW = CW + 1;

   cnpm_pkg::mac_ctl_type ctl1_ff, ctl2_ff, ctl3_ff, ctl4_ff;
   logic [PW-1:0] prod_ff, prod2_ff;
   logic [CW-1:0] q_ff;
   logic [RW-1:0] rem_ff;
   logic [CW-1:0] term_ff;
   logic [CW-1:0] acc_ff;
   logic          res_valid_ff;

   logic [WW-1:0] q_wide;
   logic [PW-1:0] q_mul;
   logic [PW-1:0] rem_wide;
   logic [CW-1:0] red;
   logic [CW-1:0] term_in;
   logic [RW-1:0] acc_sum;
   logic [CW-1:0] acc_in;

   always_comb begin
      q_wide   = WW'(prod_ff) * WW'(cnpm_pkg::MOD_RECIP);
      q_mul    = PW'(q_ff) * PW'(cnpm_pkg::COEFF_MOD);
      rem_wide = prod2_ff - q_mul;
      if (rem_ff >= RW'(cnpm_pkg::COEFF_MOD)) begin
         red = CW'(rem_ff - RW'(cnpm_pkg::COEFF_MOD));
      end else begin
         red = CW'(rem_ff);
      end
      if (ctl3_ff.neg && (red != '0)) begin
         term_in = CW'(cnpm_pkg::COEFF_MOD) - red;
      end else begin
         term_in = red;
      end
      acc_sum = RW'(term_ff) + (ctl4_ff.first ? '0 : RW'(acc_ff));
      if (acc_sum >= RW'(cnpm_pkg::COEFF_MOD)) begin
         acc_in = CW'(acc_sum - RW'(cnpm_pkg::COEFF_MOD));
      end else begin
         acc_in = CW'(acc_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff      <= '0;
         ctl2_ff      <= '0;
         ctl3_ff      <= '0;
         ctl4_ff      <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         ctl1_ff      <= ctl;
         ctl2_ff      <= ctl1_ff;
         ctl3_ff      <= ctl2_ff;
         ctl4_ff      <= ctl3_ff;
         res_valid_ff <= ctl4_ff.valid && ctl4_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= PW'(op_a) * PW'(op_b);
      prod2_ff <= prod_ff;
      q_ff     <= q_wide[cnpm_pkg::MOD_SHIFT +: CW];
      rem_ff   <= rem_wide[RW-1:0];
      term_ff  <= term_in;
      if (ctl4_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   assign res_valid = res_valid_ff;
   assign res_coeff = acc_ff;

endmodule

// ===== rtl/cyclic_negacyclic_poly_multiplier_top.sv =====
// Top level of the cyclic / negacyclic schoolbook polynomial multiplier mod 499.
//
// A load request goes through index wrap, then one RAM write, and a read request
// through index wrap, one RAM read, then the registered read data into the
// result register. A read result sits in an output register, so later requests
// go on while it waits; a second read waits until that register frees up. In a
// multiply for ring length n, one shared multiply/reduce/accumulate pipeline
// takes one term per cycle, each product coefficient being a run of n terms, and
// the product entries at or beyond n are then cleared one per cycle. No request
// is taken during a multiply, and register writes are taken only while the
// sequencer is idle. The product store reads as zero until the first multiply;
// the operand stores hold garbage until loaded.
`include "cyclic_negacyclic_poly_multiplier_top_defines.svh"

module cyclic_negacyclic_poly_multiplier_top #(
   parameter int unsigned MAX_LENGTH = cnpm_pkg::DEFAULT_MAX_LENGTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [cnpm_pkg::CMD_WIDTH-1:0]         req_command,
   input  logic [cnpm_pkg::INDEX_WIDTH-1:0]       req_coeff_index,
   input  logic [cnpm_pkg::COEFF_WIDTH-1:0]       req_coeff_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [cnpm_pkg::COEFF_WIDTH-1:0]       rsp_product_coeff,
   output logic [cnpm_pkg::INDEX_WIDTH-1:0]       rsp_product_index,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [cnpm_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [cnpm_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);

   localparam int unsigned CW         = cnpm_pkg::COEFF_WIDTH;
   localparam int unsigned IW         = cnpm_pkg::INDEX_WIDTH;
   localparam int unsigned AW         = $clog2(MAX_LENGTH);
   localparam int unsigned NW         = $clog2(MAX_LENGTH + 1);
   localparam int unsigned LW         = (NW > cnpm_pkg::LENGTH_WIDTH) ?
                                        NW : cnpm_pkg::LENGTH_WIDTH;
   localparam int unsigned JW         = NW + 1;
   localparam int unsigned IDX_SHIFT  = IW + AW;
   localparam int unsigned IDX_RECIP  = (1 << IDX_SHIFT) / MAX_LENGTH;
   localparam int unsigned RCW        = $clog2(IDX_RECIP + 1);
   localparam int unsigned QPW        = IW + RCW;
   localparam int unsigned XW         = IW + AW + 1;

   cnpm_pkg::state_type   state_ff, state_in;
   cnpm_pkg::cmd_type     cmd_ff, cmd_in;
   cnpm_pkg::mac_ctl_type tag_ff, tag_in;

   logic [IW-1:0]                       idx_ff, idx_in;
   logic [CW-1:0]                       val_ff, val_in;
   logic [IW-1:0]                       q_ff, q_in;
   logic [XW-1:0]                       rem_ff, rem_in;
   logic [AW-1:0]                       i_ff, i_in;
   logic [AW-1:0]                       k_ff, k_in;
   logic [NW-1:0]                       wr_k_ff, wr_k_in;
   logic                                prod_valid_ff, prod_valid_in;
   logic                                mode_ff;
   logic [cnpm_pkg::LENGTH_WIDTH-1:0]   ring_length_ff;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]                       rsp_coeff_ff, rsp_coeff_in;
   logic [IW-1:0]                       rsp_index_ff, rsp_index_in;

   logic [LW-1:0]  n_wide;
   logic [NW-1:0]  n_act;
   logic [QPW-1:0] q_wide;
   logic [XW-1:0]  q_mul;
   logic [XW-1:0]  rem_raw;
   logic [JW-1:0]  j_wide;
   logic           wrap;
   logic           last_i;

   logic           first_wr_en, second_wr_en;
   logic           first_rd_en, second_rd_en, product_rd_en;
   logic           product_wr_en;
   logic [AW-1:0]  product_wr_addr;
   logic [CW-1:0]  product_wr_data;
   logic [CW-1:0]  first_rd_data, second_rd_data, product_rd_data;
   logic           mac_res_valid;
   logic [CW-1:0]  mac_res_coeff;

   // configuration
   assign csr_ready = state_ff == cnpm_pkg::ST_IDLE;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= 1'b0;
         ring_length_ff <= cnpm_pkg::LENGTH_WIDTH'(cnpm_pkg::RESET_RING_LENGTH);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            cnpm_pkg::CSR_REDUCTION_MODE: mode_ff <= csr_data[0];
            cnpm_pkg::CSR_RING_LENGTH:    ring_length_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      n_wide = LW'(ring_length_ff);
      if (n_wide < LW'(cnpm_pkg::MIN_RING_LENGTH)) begin
         n_wide = LW'(cnpm_pkg::MIN_RING_LENGTH);
      end else if (n_wide > LW'(MAX_LENGTH)) begin
         n_wide = LW'(MAX_LENGTH);
      end
      n_act = NW'(n_wide);
   end

   // index wrap modulo MAX_LENGTH: reciprocal estimate, then one correction
   always_comb begin
      q_wide  = QPW'(idx_ff) * QPW'(IDX_RECIP);
      q_in    = IW'(q_wide >> IDX_SHIFT);
      q_mul   = XW'(q_ff) * XW'(MAX_LENGTH);
      rem_raw = XW'(idx_ff) - q_mul;
      if (rem_raw >= XW'(MAX_LENGTH)) begin
         rem_in = rem_raw - XW'(MAX_LENGTH);
      end else begin
         rem_in = rem_raw;
      end
   end

   // term addressing for product coefficient k
   always_comb begin
      wrap = i_ff > k_ff;
      if (wrap) begin
         j_wide = JW'(k_ff) + JW'(n_act) - JW'(i_ff);
      end else begin
         j_wide = JW'(k_ff) - JW'(i_ff);
      end
      last_i = NW'(i_ff) == (n_act - NW'(1));
   end

   always_comb begin
      if (req_coeff_value >= CW'(cnpm_pkg::COEFF_MOD)) begin
         val_in = req_coeff_value - CW'(cnpm_pkg::COEFF_MOD);
      end else begin
         val_in = req_coeff_value;
      end
      idx_in = req_coeff_index;
      cmd_in = cnpm_pkg::cmd_type'(req_command);
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      i_in          = i_ff;
      k_in          = k_ff;
      wr_k_in       = wr_k_ff;
      prod_valid_in = prod_valid_ff;
      tag_in        = '0;
      req_ready     = 1'b0;
      first_wr_en   = 1'b0;
      second_wr_en  = 1'b0;
      first_rd_en   = 1'b0;
      second_rd_en  = 1'b0;
      product_rd_en = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_coeff_in  = rsp_coeff_ff;
      rsp_index_in  = rsp_index_ff;

      product_wr_en   = 1'b0;
      product_wr_addr = wr_k_ff[AW-1:0];
      product_wr_data = mac_res_coeff;
      if (mac_res_valid) begin
         product_wr_en = 1'b1;
         wr_k_in       = wr_k_ff + NW'(1);
      end

      unique case (state_ff)
         cnpm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = cnpm_pkg::ST_WRAP_Q;
            end
         end
         cnpm_pkg::ST_WRAP_Q: begin
            state_in = cnpm_pkg::ST_WRAP_R;
         end
         cnpm_pkg::ST_WRAP_R: begin
            state_in = cnpm_pkg::ST_EXEC;
         end
         cnpm_pkg::ST_EXEC: begin
            unique case (cmd_ff)
               cnpm_pkg::CMD_LOAD_FIRST: begin
                  first_wr_en = 1'b1;
                  state_in    = cnpm_pkg::ST_IDLE;
               end
               cnpm_pkg::CMD_LOAD_SECOND: begin
                  second_wr_en = 1'b1;
                  state_in     = cnpm_pkg::ST_IDLE;
               end
               cnpm_pkg::CMD_READ: begin
                  product_rd_en = 1'b1;
                  state_in      = cnpm_pkg::ST_READ;
               end
               cnpm_pkg::CMD_MULTIPLY: begin
                  i_in          = '0;
                  k_in          = '0;
                  wr_k_in       = '0;
                  prod_valid_in = 1'b1;
                  state_in      = cnpm_pkg::ST_MUL_RUN;
               end
               default: state_in = cnpm_pkg::ST_IDLE;
            endcase
         end
         cnpm_pkg::ST_READ: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_coeff_in = prod_valid_ff ? product_rd_data : '0;
               rsp_index_in = rem_ff[IW-1:0];
               state_in     = cnpm_pkg::ST_IDLE;
            end
         end
         cnpm_pkg::ST_MUL_RUN: begin
            first_rd_en  = 1'b1;
            second_rd_en = 1'b1;
            tag_in.valid = 1'b1;
            tag_in.neg   = mode_ff && wrap;
            tag_in.first = i_ff == '0;
            tag_in.last  = last_i;
            if (last_i) begin
               i_in = '0;
               if (NW'(k_ff) == (n_act - NW'(1))) begin
                  state_in = cnpm_pkg::ST_MUL_DRAIN;
               end else begin
                  k_in = k_ff + AW'(1);
               end
            end else begin
               i_in = i_ff + AW'(1);
            end
         end
         cnpm_pkg::ST_MUL_DRAIN: begin
            if (wr_k_ff == n_act) begin
               if (n_act == NW'(MAX_LENGTH)) begin
                  state_in = cnpm_pkg::ST_IDLE;
               end else begin
                  state_in = cnpm_pkg::ST_MUL_CLEAR;
               end
            end
         end
         cnpm_pkg::ST_MUL_CLEAR: begin
            product_wr_en   = 1'b1;
            product_wr_data = '0;
            wr_k_in         = wr_k_ff + NW'(1);
            if (wr_k_ff == NW'(MAX_LENGTH - 1)) begin
               state_in = cnpm_pkg::ST_IDLE;
            end
         end
         default: state_in = cnpm_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= cnpm_pkg::ST_IDLE;
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         tag_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         prod_valid_ff <= prod_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         tag_ff        <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff <= cmd_in;
         idx_ff <= idx_in;
         val_ff <= val_in;
      end
      q_ff         <= q_in;
      rem_ff       <= rem_in;
      i_ff         <= i_in;
      k_ff         <= k_in;
      wr_k_ff      <= wr_k_in;
      rsp_coeff_ff <= rsp_coeff_in;
      rsp_index_ff <= rsp_index_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_product_coeff = rsp_coeff_ff;
   assign rsp_product_index = rsp_index_ff;

   cnpm_ram #(
      .WIDTH (CW),
      .DEPTH (MAX_LENGTH)
   ) u_first (
      .clock   (clock),
      .wr_en   (first_wr_en),
      .wr_addr (rem_ff[AW-1:0]),
      .wr_data (val_ff),
      .rd_en   (first_rd_en),
      .rd_addr (i_ff),
      .rd_data (first_rd_data)
   );

   cnpm_ram #(
      .WIDTH (CW),
      .DEPTH (MAX_LENGTH)
   ) u_second (
      .clock   (clock),
      .wr_en   (second_wr_en),
      .wr_addr (rem_ff[AW-1:0]),
      .wr_data (val_ff),
      .rd_en   (second_rd_en),
      .rd_addr (j_wide[AW-1:0]),
      .rd_data (second_rd_data)
   );

   cnpm_ram #(
      .WIDTH (CW),
      .DEPTH (MAX_LENGTH)
   ) u_product (
      .clock   (clock),
      .wr_en   (product_wr_en),
      .wr_addr (product_wr_addr),
      .wr_data (product_wr_data),
      .rd_en   (product_rd_en),
      .rd_addr (rem_ff[AW-1:0]),
      .rd_data (product_rd_data)
   );

   cnpm_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .ctl       (tag_ff),
      .op_a      (first_rd_data),
      .op_b      (second_rd_data),
      .res_valid (mac_res_valid),
      .res_coeff (mac_res_coeff)
   );

   `CNPM_ASSERT_IMP(a_rsp_from_read, $rose(rsp_valid_ff),
      $past(state_ff) == cnpm_pkg::ST_READ, "response raised outside a read")
   `CNPM_ASSERT_IMP(a_mac_in_multiply, mac_res_valid,
      state_ff == cnpm_pkg::ST_MUL_RUN || state_ff == cnpm_pkg::ST_MUL_DRAIN,
      "MAC result outside a multiply")
   `CNPM_ASSERT_IMP(a_drain_count, state_ff == cnpm_pkg::ST_MUL_DRAIN,
      wr_k_ff <= n_act, "more product coefficients than ring length")
   `CNPM_ASSERT_NEXT(a_multiply_start,
      state_ff == cnpm_pkg::ST_EXEC && cmd_ff == cnpm_pkg::CMD_MULTIPLY,
      prod_valid_ff && state_ff == cnpm_pkg::ST_MUL_RUN, "multiply did not start")

endmodule
